// ----- rtl/ps_pkg.sv -----
// types, constants and helper functions shared by the partitioned multi-stack
package ps_pkg;

  localparam int DEPTH       = 16;
  localparam int MAX_STACKS  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int DW          = 32;
  localparam int AW          = $clog2(DEPTH);
  localparam int CW          = $clog2(DEPTH + 1);
  localparam int IDW         = $clog2(MAX_STACKS);
  localparam int NSW         = $clog2(MAX_STACKS + 1);
  localparam int MAXR        = (MAX_RESULTS < DEPTH) ? MAX_RESULTS : DEPTH;
  localparam int QDEPTH      = 2;
  localparam int QAW         = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_SHOW = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BADID = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_SHOW = 2'd2,
    OP_BAD  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_WAIT = 2'd2,
    S_EMIT = 2'd3
  } state_e;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [IDW-1:0]       stack_id;
    logic signed [DW-1:0] push_value;
  } ps_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [DW-1:0] out_value;
    logic                 last;
  } ps_out_t;

  typedef struct packed {
    op_e                  op;
    logic [IDW-1:0]       stack_id;
    logic signed [DW-1:0] value;
  } ps_cmd_t;

  function automatic logic [NSW-1:0] clamp_num(logic [NSW-1:0] v);
    logic [NSW-1:0] r;
    if (v == '0) begin
      r = NSW'(1);
    end else if (v > NSW'(MAX_STACKS)) begin
      r = NSW'(MAX_STACKS);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] part_size(logic [NSW-1:0] n);
    logic [CW-1:0] p;
    case (n)
      NSW'(1):  p = CW'(DEPTH / 1);
      NSW'(2):  p = CW'(DEPTH / 2);
      NSW'(3):  p = CW'(DEPTH / 3);
      NSW'(4):  p = CW'(DEPTH / 4);
      NSW'(5):  p = CW'(DEPTH / 5);
      NSW'(6):  p = CW'(DEPTH / 6);
      NSW'(7):  p = CW'(DEPTH / 7);
      NSW'(8):  p = CW'(DEPTH / 8);
      NSW'(9):  p = CW'(DEPTH / 9);
      NSW'(10): p = CW'(DEPTH / 10);
      NSW'(11): p = CW'(DEPTH / 11);
      NSW'(12): p = CW'(DEPTH / 12);
      NSW'(13): p = CW'(DEPTH / 13);
      NSW'(14): p = CW'(DEPTH / 14);
      NSW'(15): p = CW'(DEPTH / 15);
      NSW'(16): p = CW'(DEPTH / 16);
      default:  p = CW'(DEPTH);
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/ps_ram.sv -----
// generic single-port-write ram with registered read
module ps_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ps_queue.sv -----
// short command queue between the front and back parts
module ps_queue
  import ps_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  ps_cmd_t cmd_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output ps_cmd_t cmd_o
);

  ps_cmd_t        entry_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   count_q, count_d;

  assign full_o  = (count_q == (QAW + 1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QAW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QAW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (QAW + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QAW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/ps_front.sv -----
// front part: accepts request items and classifies them into commands
module ps_front
  import ps_pkg::*;
(
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ps_in_t         in_item_i,
  input  logic [NSW-1:0] num_stacks_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output ps_cmd_t        q_cmd_o
);

  logic accept;
  logic bad_id;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign bad_id     = (NSW'(in_item_i.stack_id) >= num_stacks_i);

  always_comb begin
    q_cmd_o.stack_id = in_item_i.stack_id;
    q_cmd_o.value    = in_item_i.push_value;
    q_cmd_o.op       = OP_BAD;
    q_push_o         = 1'b0;
    case (req_e'(in_item_i.req_type))
      REQ_PUSH: begin
        q_cmd_o.op = bad_id ? OP_BAD : OP_PUSH;
        q_push_o   = accept;
      end
      REQ_POP: begin
        q_cmd_o.op = bad_id ? OP_BAD : OP_POP;
        q_push_o   = accept;
      end
      REQ_SHOW: begin
        q_cmd_o.op = bad_id ? OP_BAD : OP_SHOW;
        q_push_o   = accept;
      end
      default: begin
        // unused request type is dropped
        q_push_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/ps_back.sv -----
// back part: fill counts, word store and result register
module ps_back
  import ps_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_clear_i,
  input  logic [NSW-1:0] num_stacks_i,
  input  logic           cmd_valid_i,
  input  ps_cmd_t        cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ps_out_t        out_item_o
);

  state_e          state_q, state_d;
  ps_cmd_t         cmd_q;
  logic [CW-1:0]   part_q;
  logic [AW-1:0]   base_q;
  logic [CW-1:0]   fill_q;
  logic [AW-1:0]   addr_q, addr_d;
  logic [CW-1:0]   remain_q, remain_d;
  logic [CW-1:0]   fill_cnt_q [MAX_STACKS];
  logic            out_valid_q;
  ps_out_t         out_q;

  logic            free;
  logic            emit;
  ps_out_t         res;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [DW-1:0]   ram_rdata;
  logic            fill_we;
  logic [CW-1:0]   fill_wdata;
  logic [CW-1:0]   part_now;
  logic [IDW+CW-1:0] base_full;
  logic [CW-1:0]   top_sum;

  assign free      = !out_valid_q || out_ready_i;
  assign part_now  = part_size(num_stacks_i);
  assign base_full = (IDW + CW)'(cmd_i.stack_id) * (IDW + CW)'(part_now);
  assign top_sum   = CW'(base_q) + fill_q;
  assign ram_waddr = top_sum[AW-1:0];

  ps_ram #(
    .Width(DW),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(cmd_q.value),
    .raddr_i(addr_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    cmd_pop_o  = 1'b0;
    emit       = 1'b0;
    res        = '0;
    ram_we     = 1'b0;
    fill_we    = 1'b0;
    fill_wdata = fill_q;
    addr_d     = addr_q;
    remain_d   = remain_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_q.op)
          OP_BAD: begin
            if (free) begin
              emit       = 1'b1;
              res.status = ST_BADID;
              res.last   = 1'b1;
              state_d    = S_IDLE;
            end
          end
          OP_PUSH: begin
            if (free) begin
              emit     = 1'b1;
              res.last = 1'b1;
              state_d  = S_IDLE;
              if (fill_q >= part_q) begin
                res.status = ST_FULL;
              end else begin
                res.status = ST_OK;
                ram_we     = 1'b1;
                fill_we    = 1'b1;
                fill_wdata = fill_q + CW'(1);
              end
            end
          end
          default: begin
            if (fill_q == '0) begin
              if (free) begin
                emit       = 1'b1;
                res.status = ST_EMPTY;
                res.last   = 1'b1;
                state_d    = S_IDLE;
              end
            end else begin
              addr_d   = AW'(top_sum - CW'(1));
              remain_d = (fill_q > CW'(MAXR)) ? CW'(MAXR) : fill_q;
              state_d  = S_WAIT;
              if (cmd_q.op == OP_POP) begin
                fill_we    = 1'b1;
                fill_wdata = fill_q - CW'(1);
                remain_d   = CW'(1);
              end
            end
          end
        endcase
      end
      S_WAIT: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (free) begin
          emit          = 1'b1;
          res.status    = ST_OK;
          res.out_value = ram_rdata;
          res.last      = (remain_q == CW'(1));
          if (remain_q == CW'(1)) begin
            state_d = S_IDLE;
          end else begin
            remain_d = remain_q - CW'(1);
            addr_d   = addr_q - AW'(1);
            state_d  = S_WAIT;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_STACKS; i++) begin
        fill_cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_clear_i) begin
        for (int i = 0; i < MAX_STACKS; i++) begin
          fill_cnt_q[i] <= '0;
        end
      end else if (fill_we) begin
        fill_cnt_q[cmd_q.stack_id] <= fill_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q  <= cmd_i;
      part_q <= part_now;
      base_q <= base_full[AW-1:0];
      fill_q <= fill_cnt_q[cmd_i.stack_id];
    end
    addr_q   <= addr_d;
    remain_q <= remain_d;
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- rtl/partitioned_multi_stack.sv -----
// top level of the partitioned multi-stack
// A shared store of DEPTH words is split into num_stacks equal partitions, one
// stack each. A push, a request with a bad id, or a pop or display on an empty
// stack is answered in S_EXEC; a pop passes S_WAIT and S_EMIT once, a display of
// n words once per word, paced by the single read port of the word store with its
// registered read, which the back part uses for one word at a time. A two-entry
// queue lets the front take up to two more requests meanwhile.
module partitioned_multi_stack
  import ps_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ps_in_t         in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ps_out_t        out_item_o,
  input  logic           cfg_we_i,
  input  logic [NSW-1:0] cfg_data_i
);

  logic [NSW-1:0] num_stacks_q;
  logic           q_full;
  logic           q_push;
  logic           q_valid;
  logic           q_pop;
  ps_cmd_t        q_wcmd;
  ps_cmd_t        q_rcmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_stacks_q <= NSW'(1);
    end else if (cfg_we_i) begin
      num_stacks_q <= clamp_num(cfg_data_i);
    end
  end

  ps_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .num_stacks_i(num_stacks_q),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_wcmd)
  );

  ps_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_wcmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (q_rcmd)
  );

  ps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_clear_i (cfg_we_i),
    .num_stacks_i(num_stacks_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_rcmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // error results carry no word and end the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ST_OK) |->
      (out_item_o.out_value == '0) && out_item_o.last)
    else $error("error result with data or without last");

  // partition count stays within its legal range after any write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (num_stacks_q != '0) && (num_stacks_q <= NSW'(MAX_STACKS)))
    else $error("num_stacks out of range");

  // a waiting result item holds until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

endmodule

// ----- test/ps_checker.sv -----
// checker for the partitioned multi-stack: stack predictor and result comparison
module ps_checker
  import ps_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  ps_in_t         in_item_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  ps_out_t        out_item_i,
  input  logic           cfg_we_i,
  input  logic [NSW-1:0] cfg_data_i,
  output int             err_count_o,
  output int             pending_o,
  output int             checked_o
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [DW-1:0] word_mem [DEPTH];
  int            fill_cnt [MAX_STACKS];
  int            stack_cnt = 1;
  ps_out_t       stack_results_q [$];
  int            errs = 0;
  int            checked = 0;

  function automatic void queue_result(status_e st, logic [DW-1:0] v, logic lst);
    ps_out_t r;
    r.status    = st;
    r.out_value = v;
    r.last      = lst;
    stack_results_q.push_back(r);
  endfunction

  function automatic void apply_stack_count(logic [NSW-1:0] v);
    int n;
    n = int'(v);
    if (n == 0) begin
      n = 1;
    end else if (n > MAX_STACKS) begin
      n = MAX_STACKS;
    end
    stack_cnt = n;
    foreach (fill_cnt[i]) fill_cnt[i] = 0;
  endfunction

  function automatic void predict_stack_op(ps_in_t it);
    int part;
    int base;
    int fill;
    int id;
    int n;
    id = int'(it.stack_id);
    if (it.req_type == REQ_NONE) begin
      return;
    end
    if (id >= stack_cnt) begin
      queue_result(ST_BADID, '0, 1'b1);
      return;
    end
    part = DEPTH / stack_cnt;
    base = id * part;
    fill = fill_cnt[id];
    case (it.req_type)
      REQ_PUSH: begin
        if (fill >= part) begin
          queue_result(ST_FULL, '0, 1'b1);
        end else begin
          word_mem[base + fill] = it.push_value;
          fill_cnt[id] = fill + 1;
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      REQ_POP: begin
        if (fill == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          fill_cnt[id] = fill - 1;
          queue_result(ST_OK, word_mem[base + fill - 1], 1'b1);
        end
      end
      default: begin
        if (fill == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          n = (fill > MAX_RESULTS) ? MAX_RESULTS : fill;
          for (int i = 0; i < n; i++) begin
            queue_result(ST_OK, word_mem[base + fill - 1 - i], (i + 1 == n));
          end
        end
      end
    endcase
  endfunction

  function automatic void check_result(ps_out_t got);
    ps_out_t want;
    if (stack_results_q.size() == 0) begin
      errs++;
      if (errs <= 10) begin
        $display("mismatch: unexpected item status %0d value %0d last %0d",
                 got.status, got.out_value, got.last);
      end
      return;
    end
    want = stack_results_q.pop_front();
    checked++;
    if (got.status !== want.status || got.out_value !== want.out_value ||
        got.last !== want.last) begin
      errs++;
      if (errs <= 10) begin
        $display("mismatch: expected status %0d value %0d last %0d, got %0d %0d %0d",
                 want.status, want.out_value, want.last,
                 got.status, got.out_value, got.last);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_cnt = 1;
      foreach (fill_cnt[i]) fill_cnt[i] = 0;
      stack_results_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_item_i);
      if (in_valid_i && in_ready_i) predict_stack_op(in_item_i);
      if (cfg_we_i) apply_stack_count(cfg_data_i);
    end
    err_count_o <= errs;
    pending_o   <= stack_results_q.size();
    checked_o   <= checked;
  end

endmodule

// ----- test/tb.sv -----
// testbench top for the partitioned multi-stack: stimulus, flow control and verdict
module tb;
  import ps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE      = 40;
  localparam int IDLE_LIMIT  = 2000;

  logic           clk_i;
  logic           rst_ni     = 1'b0;
  logic           in_valid   = 1'b0;
  logic           in_ready;
  ps_in_t         in_item    = '0;
  logic           out_valid;
  logic           out_ready  = 1'b0;
  ps_out_t        out_item;
  logic           cfg_we     = 1'b0;
  logic [NSW-1:0] cfg_data   = '0;

  int err_count;
  int pending;
  int checked;
  int cur_stacks = 1;
  int n_sent     = 0;
  int n_cfg      = 0;
  int burst_left = 0;
  int idle_cyc   = 0;
  bit no_gaps    = 1'b0;
  bit hold_req   = 1'b0;

  partitioned_multi_stack u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  ps_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_item_i (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .err_count_o(err_count),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // output side: segments of always ready, random and periodic stalls, and a long stall on request
  initial begin
    int mode;
    int seg_len;
    int period;
    int cyc;
    cyc = 0;
    forever begin
      mode    = $urandom_range(0, 2);
      seg_len = $urandom_range(10, 60);
      period  = $urandom_range(2, 5);
      for (int k = 0; k < seg_len; k++) begin
        @(posedge clk_i);
        cyc++;
        if (hold_req) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_req = 1'b0;
        end else if (mode == 0) begin
          out_ready <= 1'b1;
        end else if (mode == 1) begin
          out_ready <= ($urandom_range(0, 99) < 60);
        end else begin
          out_ready <= (cyc % period == 0);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cyc <= 0;
      end else if (idle_cyc >= IDLE_LIMIT) begin
        $display("timeout: no item accepted for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cyc <= idle_cyc + 1;
      end
    end
  end

  function automatic ps_in_t make_req(req_e op, int id, logic [DW-1:0] v);
    ps_in_t it;
    it.req_type   = op;
    it.stack_id   = id[IDW-1:0];
    it.push_value = v;
    return it;
  endfunction

  function automatic logic [DW-1:0] pick_word();
    logic [DW-1:0] v;
    case ($urandom_range(0, 11))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7fff_ffff;
      2:       v = '0;
      3:       v = '1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic ps_in_t pick_stack_op(int push_pct);
    int r;
    int id;
    req_e op;
    r  = $urandom_range(0, 99);
    id = $urandom_range(0, cur_stacks - 1);
    if (r < (push_pct)) begin
      op = REQ_PUSH;
    end else if (r < push_pct + (100 - push_pct) * 2 / 3) begin
      op = REQ_POP;
    end else begin
      op = REQ_SHOW;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      op = REQ_NONE;
      id = $urandom_range(0, 15);
    end else if (r < 10 && cur_stacks < MAX_STACKS) begin
      id = $urandom_range(cur_stacks, 15);
    end
    return make_req(op, id, pick_word());
  endfunction

  task automatic send_item(input ps_in_t it);
    int gap;
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (!no_gaps && gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_stack_count(input int v);
    wait_drained();
    cfg_data <= v[NSW-1:0];
    cfg_we   <= 1'b1;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    n_cfg++;
    cur_stacks = (v == 0) ? 1 : (v > MAX_STACKS) ? MAX_STACKS : v;
  endtask

  task automatic run_phase(input int cfg, input int count, input int push_pct,
                           input bit squeeze);
    ps_in_t it;
    int done;
    write_stack_count(cfg);
    if (squeeze) begin
      no_gaps  = 1'b1;
      hold_req = 1'b1;
    end
    done = 0;
    while (done < count) begin
      it = pick_stack_op(push_pct);
      send_item(it);
      if (it.req_type != REQ_NONE) done++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one stack of the whole store: empty cases, bad id, fill to full
    send_item(make_req(REQ_SHOW, 0, '0));
    send_item(make_req(REQ_POP, 0, '1));
    send_item(make_req(REQ_PUSH, 15, 32'h1234_5678));
    send_item(make_req(REQ_NONE, 0, '1));
    send_item(make_req(REQ_PUSH, 0, 32'h8000_0000));
    send_item(make_req(REQ_PUSH, 0, 32'h7fff_ffff));
    send_item(make_req(REQ_PUSH, 0, '0));
    send_item(make_req(REQ_PUSH, 0, '1));
    for (int i = 0; i < DEPTH - 4; i++) begin
      send_item(make_req(REQ_PUSH, 0, $urandom));
    end
    send_item(make_req(REQ_PUSH, 0, 32'h5555_aaaa));
    send_item(make_req(REQ_SHOW, 0, '0));
    send_item(make_req(REQ_POP, 0, '0));
    send_item(make_req(REQ_POP, 0, '0));
    send_item(make_req(REQ_SHOW, 1, '0));
    send_item(make_req(REQ_NONE, 15, '0));

    run_phase(4, 30, 55, 1'b0);
    run_phase(0, 25, 60, 1'b0);
    run_phase(3, 20, 70, 1'b1);
    run_phase(16, 30, 50, 1'b0);
    run_phase(31, 25, 50, 1'b0);
    run_phase(2, 25, 55, 1'b0);
    run_phase(5, 25, 55, 1'b0);
    run_phase(17, 20, 45, 1'b0);
    run_phase(7, 25, 55, 1'b0);
    run_phase(1, 22, 65, 1'b0);
    run_phase($urandom_range(0, 31), 25, 55, 1'b0);

    wait_drained();
    $display("covered %0d requests and %0d checked results", n_sent, checked);
    $display("over %0d stack-count writes incl. out-of-range values and a stalled output",
             n_cfg);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
